### rtl/time_slice_task_scheduler_assert.svh
// Assertion macros shared by the checker
`ifndef TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH

// implication checked every clock outside reset
`define TSTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on the next clock
`define TSTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tsts_pkg.sv
`default_nettype none
package tsts_pkg;

  localparam int unsigned TaskCountDef = 16;
  localparam int unsigned IdleTaskDef  = 15;
  localparam logic [7:0]  SliceReset   = 8'd10;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_PREPARE = 3'd1,
    CMD_START   = 3'd2,
    CMD_SLEEP   = 3'd3,
    CMD_WAKE    = 3'd4,
    CMD_FINISH  = 3'd5
  } cmd_e;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_INIT     = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_WAIT     = 3'd4;
  localparam logic [2:0] ST_SLEEPING = 3'd5;
  localparam logic [2:0] ST_DESTROY  = 3'd6;

  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_RUN   = 2'd1;
  localparam logic [1:0] TAG_WAIT  = 2'd2;
  localparam logic [1:0] TAG_SLEEP = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] task_id;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] run_task;
    logic       switched;
    logic       slices_refilled;
  } out_beat_t;

  // status move table, row = from, column = to
  function automatic logic move_ok(input logic [2:0] from, input logic [2:0] to);
    logic [7:0] row;
    case (from)
      3'd0, 3'd1: row = 8'b0111_1100;
      3'd2:       row = 8'b0111_1000;
      3'd3:       row = 8'b0111_0100;
      3'd4:       row = 8'b0110_1100;
      3'd5:       row = 8'b0100_0100;
      default:    row = 8'b0000_0000;
    endcase
    return row[to];
  endfunction

endpackage
`default_nettype wire

### rtl/time_slice_task_scheduler.sv
// Sequence: an unknown command or task goes straight to the result beat; a tick
// with slice left takes the reschedule step; prepare/start take the command and post
// steps, and sleep/wake/finish add the reschedule; a spent slice adds park, pick and a
// switch, or a refill walk over each waiting task before the current task resumes.
// Throughput: one command at a time; busy drops with the result beat.
// Reset: synchronous active low; task 0 running with 10 ticks, idle sleeping.
`default_nettype none
module time_slice_task_scheduler #(
  parameter int unsigned TASK_COUNT = tsts_pkg::TaskCountDef,
  parameter int unsigned IDLE_SLOT  = tsts_pkg::IdleTaskDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tsts_pkg::in_beat_t in_beat,
  output logic                    out_valid,
  output tsts_pkg::out_beat_t     out_beat,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  import tsts_pkg::*;

  localparam int unsigned TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int unsigned LW = TW + 1;
  localparam logic [LW-1:0] NIL = {LW{1'b1}};
  localparam logic [TW-1:0] IDLE = TW'(IDLE_SLOT);
  localparam logic IDLE_OK = (IDLE_SLOT < TASK_COUNT);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CMD    = 9'b000000010,
    S_POST   = 9'b000000100,
    S_RESCH  = 9'b000001000,
    S_PARK   = 9'b000010000,
    S_PICK   = 9'b000100000,
    S_SWNEXT = 9'b001000000,
    S_REFILL = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  // task tables
  logic [2:0]    status_r [TASK_COUNT];
  logic [7:0]    slice_r  [TASK_COUNT];
  logic [7:0]    saved_r  [TASK_COUNT];
  logic [1:0]    tag_r    [TASK_COUNT];
  logic [LW-1:0] next_r   [TASK_COUNT];
  logic [LW-1:0] prev_r   [TASK_COUNT];
  logic [LW-1:0] run_head_r, wait_head_r;
  logic [TW-1:0] running_r, before_r, tid_r, cur_r, walk_r;
  logic [2:0]    cmd_r;
  logic [7:0]    slice_ticks_r;
  logic          refill_r;
  logic [LW-1:0] walk_cnt_r;
  state_t        state_r;

  // the move engine: one status move per cycle on task mv_t
  logic          mv_en;
  logic [TW-1:0] mv_t;
  logic [2:0]    mv_to;
  logic          mv_force;   // forced move of idle to running

  assign busy = (state_r != S_IDLE);

  always_comb begin
    mv_en = 1'b0; mv_t = tid_r; mv_to = ST_NONE; mv_force = 1'b0;
    unique case (state_r)
      S_CMD: begin
        if (cmd_r == CMD_START || cmd_r == CMD_WAKE) begin
          mv_en = 1'b1; mv_to = ST_RUNNABLE;
        end else if (cmd_r == CMD_SLEEP) begin
          mv_en = 1'b1; mv_to = ST_SLEEPING;
        end else if (cmd_r == CMD_FINISH) begin
          mv_en = 1'b1; mv_to = ST_DESTROY;
        end
      end
      S_PARK: begin
        mv_en = 1'b1; mv_t = cur_r; mv_to = ST_WAIT;
      end
      S_PICK: begin
        // idle current gives way to sleep before the switch
        mv_en = (cur_r == IDLE) && IDLE_OK && (run_head_r != NIL);
        mv_t = cur_r; mv_to = ST_SLEEPING;
      end
      S_SWNEXT: begin
        mv_en = 1'b1; mv_t = walk_r; mv_to = ST_RUNNING;
        // only a switch to idle is forced; resuming after a refill follows the table
        mv_force = (walk_r == IDLE) && IDLE_OK && !refill_r;
      end
      S_REFILL: begin
        mv_en = (walk_cnt_r != NIL); mv_t = walk_r; mv_to = ST_RUNNABLE;
      end
      default: ;
    endcase
  end

  logic          allow;
  logic [2:0]    from_st;
  logic [LW-1:0] n_l, p_l;
  logic [1:0]    tag_l;
  always_comb begin
    from_st = status_r[mv_t];
    allow   = mv_force || move_ok(from_st, mv_to);
    n_l     = next_r[mv_t];
    p_l     = prev_r[mv_t];
    tag_l   = tag_r[mv_t];
  end

  logic          in_list;
  always_comb begin
    in_list = (tag_l == TAG_RUN) || (tag_l == TAG_WAIT);
  end

  // sequencer and tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        status_r[i] <= ST_NONE; slice_r[i] <= 8'd0; saved_r[i] <= 8'd0;
        tag_r[i] <= TAG_NONE; next_r[i] <= NIL; prev_r[i] <= NIL;
      end
      status_r[0] <= ST_RUNNING;
      slice_r[0]  <= SliceReset;
      if (IDLE_OK) begin
        status_r[IDLE] <= ST_SLEEPING;
        tag_r[IDLE]    <= TAG_SLEEP;
      end
      run_head_r <= NIL; wait_head_r <= NIL;
      running_r <= '0; slice_ticks_r <= SliceReset;
      state_r <= S_IDLE; out_valid <= 1'b0; refill_r <= 1'b0;
      before_r <= '0; tid_r <= '0; cur_r <= '0; walk_r <= '0; cmd_r <= '0;
      walk_cnt_r <= '0; out_beat <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) slice_ticks_r <= cfg_wdata;

      // shared list move
      if (mv_en && allow) begin
        if (in_list || mv_force) begin
          if (in_list) begin
            if (p_l != NIL) next_r[p_l[TW-1:0]] <= n_l;
            else if (tag_l == TAG_RUN) run_head_r <= n_l;
            else wait_head_r <= n_l;
            if (n_l != NIL) prev_r[n_l[TW-1:0]] <= p_l;
          end
        end
        next_r[mv_t] <= NIL; prev_r[mv_t] <= NIL; tag_r[mv_t] <= TAG_NONE;
        status_r[mv_t] <= mv_to;
        if (mv_to == ST_RUNNABLE || mv_to == ST_WAIT) begin
          // push onto head; the head never equals the unlinked task here
          if (mv_to == ST_RUNNABLE) begin
            next_r[mv_t] <= (in_list && tag_l == TAG_RUN && p_l == NIL) ? n_l : run_head_r;
            if (in_list && tag_l == TAG_RUN && p_l == NIL) begin
              if (n_l != NIL) prev_r[n_l[TW-1:0]] <= {1'b0, mv_t};
            end else if (run_head_r != NIL) prev_r[run_head_r[TW-1:0]] <= {1'b0, mv_t};
            run_head_r <= {1'b0, mv_t}; tag_r[mv_t] <= TAG_RUN;
          end else begin
            next_r[mv_t] <= (in_list && tag_l == TAG_WAIT && p_l == NIL) ? n_l : wait_head_r;
            if (in_list && tag_l == TAG_WAIT && p_l == NIL) begin
              if (n_l != NIL) prev_r[n_l[TW-1:0]] <= {1'b0, mv_t};
            end else if (wait_head_r != NIL) prev_r[wait_head_r[TW-1:0]] <= {1'b0, mv_t};
            wait_head_r <= {1'b0, mv_t}; tag_r[mv_t] <= TAG_WAIT;
          end
        end else if (mv_to == ST_SLEEPING) tag_r[mv_t] <= TAG_SLEEP;
        else if (mv_to == ST_RUNNING) running_r <= mv_t;
        else if (mv_to == ST_DESTROY) slice_r[mv_t] <= 8'd0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_beat.command; tid_r <= in_beat.task_id;
            before_r <= running_r; refill_r <= 1'b0;
            if (in_beat.command == CMD_TICK) state_r <= S_RESCH;
            else if (in_beat.command > CMD_FINISH ||
                     32'(in_beat.task_id) >= TASK_COUNT) state_r <= S_DONE;
            else state_r <= S_CMD;
          end
        end
        S_CMD: begin
          state_r <= S_POST;
        end
        S_POST: begin
          // slice bookkeeping after the status move
          unique case (cmd_r)
            CMD_PREPARE: begin slice_r[tid_r] <= slice_ticks_r; state_r <= S_DONE; end
            CMD_START: state_r <= S_DONE;
            CMD_SLEEP: begin
              saved_r[tid_r] <= slice_r[tid_r]; slice_r[tid_r] <= 8'd0; state_r <= S_RESCH;
            end
            CMD_WAKE: begin
              slice_r[tid_r] <= saved_r[tid_r]; saved_r[tid_r] <= 8'd0; state_r <= S_RESCH;
            end
            default: state_r <= S_RESCH;
          endcase
        end
        S_RESCH: begin
          cur_r <= running_r;
          if (slice_r[running_r] != 8'd0) begin
            slice_r[running_r] <= slice_r[running_r] - 8'd1;
            state_r <= S_DONE;
          end else state_r <= S_PARK;
        end
        S_PARK: state_r <= S_PICK;
        S_PICK: begin
          if (run_head_r != NIL) begin
            walk_r <= run_head_r[TW-1:0]; state_r <= S_SWNEXT;
          end else if (wait_head_r == NIL && cur_r != IDLE && IDLE_OK) begin
            walk_r <= IDLE; state_r <= S_SWNEXT;
          end else begin
            walk_r <= wait_head_r[TW-1:0]; walk_cnt_r <= wait_head_r;
            refill_r <= 1'b1; state_r <= S_REFILL;
          end
        end
        S_SWNEXT: state_r <= S_DONE;
        S_REFILL: begin
          if (walk_cnt_r != NIL) begin
            slice_r[walk_r] <= slice_ticks_r;
            walk_cnt_r <= n_l;
            walk_r <= n_l[TW-1:0];
          end else begin
            walk_r <= cur_r;
            state_r <= S_SWNEXT;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_beat.run_task <= 4'(running_r);
          out_beat.switched <= (running_r != before_r);
          out_beat.slices_refilled <= refill_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/tsts_checker.sv
`default_nettype none
`include "time_slice_task_scheduler_assert.svh"
module tsts_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire tsts_pkg::out_beat_t out_beat
);
  import tsts_pkg::*;
  // an accepted command makes the block busy next cycle
  `TSTS_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
  // a result beat lasts one cycle
  `TSTS_ASSERT_NXT(a_one_cycle_out, out_valid, !out_valid)
  // busy drops with the result beat
  `TSTS_ASSERT_IMP(a_out_not_busy, out_valid, !busy)
  // a refill keeps the running task
  `TSTS_ASSERT_IMP(a_refill_noswitch, out_valid && out_beat.slices_refilled,
    !out_beat.switched)
endmodule
bind time_slice_task_scheduler tsts_checker u_tsts_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_beat(out_beat)
);
`default_nettype wire

### bench/tb_time_slice_task_scheduler.sv
`default_nettype none
module tb_time_slice_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import tsts_pkg::*;

  localparam int NTASK = 16;
  localparam int IDLE  = 15;
  localparam int NIL   = 31;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_beat_t in_beat = '0;
  logic out_valid;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  time_slice_task_scheduler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler shadow state
  logic [7:0] ticks_per_slice;
  logic [2:0] status [NTASK];
  logic [7:0] slice_rem [NTASK];
  logic [7:0] slice_saved [NTASK];
  logic [1:0] tag [NTASK];
  int nxt [NTASK];
  int prv [NTASK];
  int run_head, wait_head, cur_task;

  out_beat_t pending_q[$];
  int fail_cnt = 0;
  int quiet_cycles = 0;

  function automatic bit move_allowed(logic [2:0] from, logic [2:0] to);
    case (from)
      ST_NONE, ST_INIT: return to inside {ST_RUNNABLE, ST_RUNNING, ST_WAIT, ST_SLEEPING,
                                          ST_DESTROY};
      ST_RUNNABLE: return to inside {ST_RUNNING, ST_WAIT, ST_SLEEPING, ST_DESTROY};
      ST_RUNNING:  return to inside {ST_RUNNABLE, ST_WAIT, ST_SLEEPING, ST_DESTROY};
      ST_WAIT:     return to inside {ST_RUNNABLE, ST_RUNNING, ST_SLEEPING, ST_DESTROY};
      ST_SLEEPING: return to inside {ST_RUNNABLE, ST_DESTROY};
      default:     return 1'b0;
    endcase
  endfunction

  function automatic void list_remove(int t);
    int n, p;
    n = nxt[t];
    p = prv[t];
    if (tag[t] == TAG_RUN || tag[t] == TAG_WAIT) begin
      if (p != NIL) nxt[p] = n;
      else if (tag[t] == TAG_RUN) run_head = n;
      else wait_head = n;
      if (n != NIL) prv[n] = p;
    end
    nxt[t] = NIL;
    prv[t] = NIL;
    tag[t] = TAG_NONE;
  endfunction

  function automatic void list_push(int t, bit to_wait);
    int h;
    h = to_wait ? wait_head : run_head;
    nxt[t] = h;
    prv[t] = NIL;
    if (h != NIL) prv[h] = t;
    if (to_wait) wait_head = t;
    else run_head = t;
    tag[t] = to_wait ? TAG_WAIT : TAG_RUN;
  endfunction

  function automatic void set_status(int t, logic [2:0] to);
    if (!move_allowed(status[t], to)) return;
    list_remove(t);
    status[t] = to;
    case (to)
      ST_RUNNABLE: list_push(t, 1'b0);
      ST_WAIT:     list_push(t, 1'b1);
      ST_SLEEPING: tag[t] = TAG_SLEEP;
      ST_RUNNING:  cur_task = t;
      ST_DESTROY:  slice_rem[t] = '0;
      default: ;
    endcase
  endfunction

  function automatic void hand_over(int from_t, int to_t);
    if (from_t == IDLE) set_status(from_t, ST_SLEEPING);
    if (to_t == IDLE) begin
      list_remove(to_t);
      status[to_t] = ST_RUNNING;
      cur_task = to_t;
    end else begin
      set_status(to_t, ST_RUNNING);
    end
  endfunction

  // returns 1 when the waiting tasks were refilled
  function automatic bit consume_tick();
    int c, p, n, g;
    c = cur_task;
    if (slice_rem[c] > 0) begin
      slice_rem[c]--;
      return 1'b0;
    end
    set_status(c, ST_WAIT);
    if (run_head != NIL) begin
      hand_over(c, run_head);
      return 1'b0;
    end
    if (wait_head == NIL && c != IDLE) begin
      hand_over(c, IDLE);
      return 1'b0;
    end
    p = wait_head;
    for (g = 0; p != NIL && g < NTASK; g++) begin
      n = nxt[p];
      slice_rem[p] = ticks_per_slice;
      set_status(p, ST_RUNNABLE);
      p = n;
    end
    set_status(c, ST_RUNNING);
    return 1'b1;
  endfunction

  function automatic void sched_reset();
    ticks_per_slice = SliceReset;
    for (int i = 0; i < NTASK; i++) begin
      status[i] = ST_NONE;
      slice_rem[i] = '0;
      slice_saved[i] = '0;
      tag[i] = TAG_NONE;
      nxt[i] = NIL;
      prv[i] = NIL;
    end
    run_head = NIL;
    wait_head = NIL;
    cur_task = 0;
    slice_rem[0] = ticks_per_slice;
    set_status(0, ST_RUNNING);
    set_status(IDLE, ST_SLEEPING);
  endfunction

  function automatic out_beat_t predict_command(in_beat_t b);
    out_beat_t r;
    int was, t;
    bit refill;
    was = cur_task;
    t = int'(b.task_id);
    refill = 1'b0;
    case (b.command)
      CMD_TICK: refill = consume_tick();
      CMD_PREPARE: slice_rem[t] = ticks_per_slice;
      CMD_START: set_status(t, ST_RUNNABLE);
      CMD_SLEEP: begin
        set_status(t, ST_SLEEPING);
        slice_saved[t] = slice_rem[t];
        slice_rem[t] = '0;
        refill = consume_tick();
      end
      CMD_WAKE: begin
        set_status(t, ST_RUNNABLE);
        slice_rem[t] = slice_saved[t];
        slice_saved[t] = '0;
        refill = consume_tick();
      end
      CMD_FINISH: begin
        set_status(t, ST_DESTROY);
        refill = consume_tick();
      end
      default: ;
    endcase
    r.run_task = cur_task[3:0];
    r.switched = (cur_task != was);
    r.slices_refilled = refill;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_beat);
        fail_cnt++;
      end else begin
        exp_b = pending_q.pop_front();
        if (out_beat.run_task !== exp_b.run_task) begin
          $display("%0t: run_task expected %0d actual %0d", $time,
                   exp_b.run_task, out_beat.run_task);
          fail_cnt++;
        end
        if (out_beat.switched !== exp_b.switched) begin
          $display("%0t: switched expected %0b actual %0b", $time,
                   exp_b.switched, out_beat.switched);
          fail_cnt++;
        end
        if (out_beat.slices_refilled !== exp_b.slices_refilled) begin
          $display("%0t: slices_refilled expected %0b actual %0b", $time,
                   exp_b.slices_refilled, out_beat.slices_refilled);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // start drops only when a gap follows
  task automatic random_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 40) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // send one command beat and record its expected result
  task automatic send_cmd(logic [2:0] cmd, logic [3:0] tid, bit gaps = 1'b1);
    in_beat_t b;
    if (gaps) random_gap();
    b.command = cmd;
    b.task_id = tid;
    in_beat <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_command(b));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    ticks_per_slice = v;
  endtask

  task automatic test_directed();
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_PREPARE, 4'd1);
    send_cmd(CMD_START, 4'd1);
    send_cmd(CMD_START, 4'd2);
    send_cmd(CMD_START, 4'd2);       // forbidden runnable to runnable
    send_cmd(CMD_SLEEP, 4'd0);       // running task sleeps
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_WAKE, 4'd0);
    send_cmd(CMD_FINISH, 4'd2);
    send_cmd(CMD_FINISH, 4'd2);      // destroy is final
    send_cmd(3'd6, 4'd3);            // unknown commands
    send_cmd(3'd7, 4'd15);
    send_cmd(CMD_SLEEP, 4'd15);
    send_cmd(CMD_WAKE, 4'd15);
    send_cmd(CMD_PREPARE, 4'd15);
    send_cmd(CMD_FINISH, 4'd1);
    send_cmd(CMD_SLEEP, 4'd0);
    for (int i = 0; i < 8; i++) send_cmd(CMD_TICK, 4'd0, 1'b0);
  endtask

  task automatic test_slice_zero();
    write_slice(8'd0);
    send_cmd(CMD_START, 4'd5);
    send_cmd(CMD_START, 4'd6);
    for (int i = 0; i < 10; i++) send_cmd(CMD_TICK, 4'd0);
  endtask

  task automatic test_slice_max();
    write_slice(8'd255);
    send_cmd(CMD_PREPARE, 4'd7);
    send_cmd(CMD_START, 4'd7);
    for (int i = 0; i < 6; i++) send_cmd(CMD_TICK, 4'd0);
  endtask

  // mostly scheduling traffic over few tasks, some noise
  task automatic test_random(int count, logic [7:0] slice);
    int r;
    logic [2:0] cmd;
    logic [3:0] tid;
    write_slice(slice);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = CMD_TICK;
      else if (r < 52) cmd = CMD_START;
      else if (r < 62) cmd = CMD_PREPARE;
      else if (r < 72) cmd = CMD_SLEEP;
      else if (r < 84) cmd = CMD_WAKE;
      else if (r < 94) cmd = CMD_FINISH;
      else cmd = 3'($urandom_range(6, 7));
      tid = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 5));
      send_cmd(cmd, tid);
      if (i == count / 2) drain();   // sender waits for all results
    end
  endtask

  initial begin
    sched_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_slice_zero();
    test_slice_max();
    test_random(280, 8'd1);
    test_random(280, 8'd3);
    test_random(250, 8'($urandom_range(1, 20)));
    drain();
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
